// ===== rtl/core/psh_pkg.sv =====
`default_nettype none

package psh_pkg;

  // Field and datapath widths.
  localparam int unsigned DataW = 64;
  localparam int unsigned CharW = 8;
  localparam int unsigned TdataInW = 8;
  localparam int unsigned CntW = 6;

  // Last bit index of a full-word pass and of a byte pass.
  localparam logic [CntW-1:0] CntWord = CntW'(DataW - 1);
  localparam logic [CntW-1:0] CntChar = CntW'(CharW - 1);
  localparam logic [CntW-1:0] CntOne = CntW'(1);

  // Configuration register indexes.
  localparam logic RegBase = 1'b0;
  localparam logic RegModulus = 1'b1;

  // Register values after reset.
  localparam logic [DataW-1:0] BaseReset = 64'd31;
  localparam logic [DataW-1:0] ModReset = 64'd1000000007;
  localparam logic [DataW-1:0] PowReset = 64'd1;

  typedef enum logic [2:0] {
    StIdle,
    StRedHash,
    StRedPow,
    StMulChar,
    StAdd,
    StMulBase,
    StDone
  } psh_state_e;

endpackage

`default_nettype wire

// ===== rtl/core/polynomial_string_hash_mod.sv =====
// Per byte: reduce hash, reduce power, multiply by the byte, add, multiply by the base, publish;
// a new byte is taken only when idle. The single modular add/reduce unit runs one bit per cycle.
// The output register lets the next byte start while a result still waits on m_axis_tready.
// Reset (rst_ni low, asynchronous): base 31, modulus 1000000007, hash 0, power 1,
// no result pending and the sequencer idle.
`default_nettype none

module polynomial_string_hash_mod (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,

  // Input stream. tdata: [7:0] char_code. tlast: last_char.
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,
  input  wire logic        s_axis_tlast,

  // Output stream. tdata: [63:0] hash_value. tlast: hash_done.
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [63:0]      m_axis_tdata,
  output logic             m_axis_tlast,

  // Configuration writes: index 0 is base_multiplier, index 1 is modulus.
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_index_i,
  input  wire logic [63:0] cfg_data_i
);

  localparam int unsigned W = psh_pkg::DataW;

  // Configuration registers.
  logic [W-1:0] base_q, mod_q;

  // Running string state.
  logic [W-1:0] hash_q, hash_d;
  logic [W-1:0] pow_q, pow_d;

  // Sequencer and shared unit operands.
  psh_pkg::psh_state_e state_q, state_d;
  logic [W-1:0]                 acc_q, acc_d;   // accumulator of the current pass
  logic [W-1:0]                 bits_q, bits_d; // multiplier bits, taken MSB first
  logic [psh_pkg::CntW-1:0]     cnt_q, cnt_d;
  logic [psh_pkg::CharW-1:0]    char_q;
  logic                         last_q;

  // Output register.
  logic         out_valid_q, out_valid_d;
  logic [W-1:0] out_hash_q, out_hash_d;
  logic         out_last_q, out_last_d;

  logic in_fire;
  assign in_fire = s_axis_tvalid && s_axis_tready;

  assign s_axis_tready = (state_q == psh_pkg::StIdle);
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_hash_q;
  assign m_axis_tlast  = out_last_q;

  // Shared unit: res = (ux + uy) mod modulus, for ux < 2*modulus and uy <= modulus.
  // The sum stays below 3*modulus, so one of the two parallel subtractions fits.
  // A zero modulus means plain 64-bit wrapping arithmetic.
  logic [W:0]   ux;
  logic [W-1:0] uy;
  logic [W+1:0] usum;
  logic [W+2:0] usub1, usub2;
  logic [W-1:0] ures;

  always_comb begin
    ux = '0;
    uy = '0;
    case (state_q)
      psh_pkg::StRedHash, psh_pkg::StRedPow: begin
        ux = {acc_q, 1'b0};
        uy = bits_q[W-1] ? psh_pkg::PowReset : '0;
      end
      psh_pkg::StMulChar, psh_pkg::StMulBase: begin
        ux = {acc_q, 1'b0};
        uy = bits_q[W-1] ? pow_q : '0;
      end
      psh_pkg::StAdd: begin
        ux = {1'b0, hash_q};
        uy = acc_q;
      end
      default: begin
        ux = '0;
        uy = '0;
      end
    endcase
  end

  always_comb begin
    usum  = {1'b0, ux} + {2'b0, uy};
    usub1 = {1'b0, usum} - {3'b0, mod_q};
    usub2 = {1'b0, usum} - {2'b0, mod_q, 1'b0};
    if (mod_q == '0) begin
      ures = usum[W-1:0];
    end else if (!usub2[W+2]) begin
      ures = usub2[W-1:0];
    end else if (!usub1[W+2]) begin
      ures = usub1[W-1:0];
    end else begin
      ures = usum[W-1:0];
    end
  end

  // Sequence per byte: reduce hash, reduce power, multiply power by the byte,
  // add into the hash, multiply power by the base, then publish the result.
  always_comb begin
    state_d     = state_q;
    hash_d      = hash_q;
    pow_d       = pow_q;
    acc_d       = acc_q;
    bits_d      = bits_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_hash_d  = out_hash_q;
    out_last_d  = out_last_q;

    case (state_q)
      psh_pkg::StIdle: begin
        if (in_fire) begin
          acc_d   = '0;
          bits_d  = hash_q;
          cnt_d   = psh_pkg::CntWord;
          state_d = psh_pkg::StRedHash;
        end
      end
      psh_pkg::StRedHash: begin
        acc_d  = ures;
        bits_d = bits_q << 1;
        cnt_d  = cnt_q - psh_pkg::CntOne;
        if (cnt_q == '0) begin
          hash_d  = ures;
          acc_d   = '0;
          bits_d  = pow_q;
          cnt_d   = psh_pkg::CntWord;
          state_d = psh_pkg::StRedPow;
        end
      end
      psh_pkg::StRedPow: begin
        acc_d  = ures;
        bits_d = bits_q << 1;
        cnt_d  = cnt_q - psh_pkg::CntOne;
        if (cnt_q == '0) begin
          pow_d   = ures;
          acc_d   = '0;
          bits_d  = {char_q, {(W - psh_pkg::CharW){1'b0}}};
          cnt_d   = psh_pkg::CntChar;
          state_d = psh_pkg::StMulChar;
        end
      end
      psh_pkg::StMulChar: begin
        acc_d  = ures;
        bits_d = bits_q << 1;
        cnt_d  = cnt_q - psh_pkg::CntOne;
        if (cnt_q == '0) begin
          state_d = psh_pkg::StAdd;
        end
      end
      psh_pkg::StAdd: begin
        hash_d  = ures;
        acc_d   = '0;
        bits_d  = base_q;
        cnt_d   = psh_pkg::CntWord;
        state_d = psh_pkg::StMulBase;
      end
      psh_pkg::StMulBase: begin
        acc_d  = ures;
        bits_d = bits_q << 1;
        cnt_d  = cnt_q - psh_pkg::CntOne;
        if (cnt_q == '0) begin
          state_d = psh_pkg::StDone;
        end
      end
      psh_pkg::StDone: begin
        // Wait here only while an older result still sits unread.
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_hash_d  = hash_q;
          out_last_d  = last_q;
          if (last_q) begin
            hash_d = '0;
            pow_d  = psh_pkg::PowReset;
          end else begin
            pow_d = acc_q;
          end
          state_d = psh_pkg::StIdle;
        end
      end
      default: begin
        state_d = psh_pkg::StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= psh_pkg::StIdle;
      hash_q      <= '0;
      pow_q       <= psh_pkg::PowReset;
      out_valid_q <= 1'b0;
      base_q      <= psh_pkg::BaseReset;
      mod_q       <= psh_pkg::ModReset;
    end else begin
      state_q     <= state_d;
      hash_q      <= hash_d;
      pow_q       <= pow_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          psh_pkg::RegBase:    base_q <= cfg_data_i;
          psh_pkg::RegModulus: mod_q  <= cfg_data_i;
          default:             base_q <= base_q;
        endcase
      end
    end
  end

  // Datapath registers without reset.
  always_ff @(posedge clk_i) begin
    acc_q      <= acc_d;
    bits_q     <= bits_d;
    cnt_q      <= cnt_d;
    out_hash_q <= out_hash_d;
    out_last_q <= out_last_d;
    if (in_fire) begin
      char_q <= s_axis_tdata[psh_pkg::CharW-1:0];
      last_q <= s_axis_tlast;
    end
  end

  // A byte taken in starts a pass, so the block is busy on the next cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while a byte was still in work");

  // The multiply accumulator stays reduced under a nonzero modulus.
  a_acc_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == psh_pkg::StMulChar || state_q == psh_pkg::StMulBase) && mod_q != '0
    |-> acc_q < mod_q)
    else $error("multiply accumulator not below the modulus");

  // The hash about to be published is reduced under a nonzero modulus.
  a_hash_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == psh_pkg::StDone && mod_q != '0 |-> hash_q < mod_q)
    else $error("hash not below the modulus at publish");

  // A result is only loaded from the publish step.
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q ##1 out_valid_q |-> $past(state_q) == psh_pkg::StDone)
    else $error("result appeared outside the publish step");

endmodule

`default_nettype wire
